[design/daylight_gated_lamp_switch_unit_defines.svh]
// Assertion macros shared by the lamp switch checker.
// No dependencies; include by bare file name.
`ifndef DAYLIGHT_GATED_LAMP_SWITCH_UNIT_DEFINES_SVH
`define DAYLIGHT_GATED_LAMP_SWITCH_UNIT_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define DGLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define DGLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/dgls_pkg.sv]
// Types, constants and helpers for the daylight gated lamp switch.
// No dependencies; imported by the top level and the checker.
package dgls_pkg;

	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned MOD_W       = 11;  // minute of day, up to 31*60+63

	localparam int unsigned MINUTES_PER_HOUR = 60;

	typedef enum logic [1:0] {
		OP_CHECK      = 2'd0,
		OP_MANUAL_ON  = 2'd1,
		OP_MANUAL_OFF = 2'd2,
		OP_AUTO       = 2'd3
	} op_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DARK_THRESHOLD = 3'd0,
		REG_HOLD_SECONDS   = 3'd1,
		REG_START_HOUR     = 3'd2,
		REG_START_MINUTE   = 3'd3,
		REG_STOP_HOUR      = 3'd4,
		REG_STOP_MINUTE    = 3'd5
	} reg_idx_t;

	localparam logic [15:0] RST_DARK_THRESHOLD = 16'd1000;
	localparam logic [15:0] RST_HOLD_SECONDS   = 16'd300;
	localparam logic [4:0]  RST_START_HOUR     = 5'd6;
	localparam logic [5:0]  RST_START_MINUTE   = 6'd0;
	localparam logic [4:0]  RST_STOP_HOUR      = 5'd18;
	localparam logic [5:0]  RST_STOP_MINUTE    = 6'd0;

	typedef struct packed {
		logic [15:0] light_level;
		logic [5:0]  day_minute;
		logic [4:0]  day_hour;
		logic        clock_known;
		logic [31:0] now_seconds;
	} sample_t;

	function automatic logic [MOD_W-1:0] minute_of_day(input logic [4:0] hr,
			input logic [5:0] mn);
		minute_of_day = MOD_W'(hr) * MOD_W'(MINUTES_PER_HOUR) + MOD_W'(mn);
	endfunction

endpackage

[design/daylight_gated_lamp_switch_unit.sv]
// Result path: the input stage registers the transaction, then the result register holds the result.
// Throughput: one transaction per cycle; the result register stalls the input stage
// only while a result waits and the input stage is also full.
// Reset (arst_n low, asynchronous) clears both stages, restores register defaults,
// lamp off, automatic mode, timers idle, dark preset armed.
// Top level of the daylight gated lamp switch; depends on dgls_pkg.
module daylight_gated_lamp_switch_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dgls_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [dgls_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// now_seconds[31:0], clock_known[32], day_hour[37:33], day_minute[43:38],
	// light_level[59:44], zero fill
	input  logic [dgls_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic [1:0]                           s_axis_tuser,  // op
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// lamp_on[0], manual_active[1], zero fill
	output logic [dgls_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import dgls_pkg::*;

	logic [15:0] dark_threshold_q, hold_seconds_q;
	logic [4:0]  start_hour_q, stop_hour_q;
	logic [5:0]  start_minute_q, stop_minute_q;

	logic        valid_s1;
	op_t         op_s1;
	sample_t     smp_s1;

	logic        lamp_q, manual_q, preset_q;
	logic [31:0] dark_since_q, bright_since_q;
	logic        lamp_n, manual_n, preset_n;
	logic [31:0] dark_since_n, bright_since_n;

	logic        out_valid_q;
	logic [1:0]  out_data_q;

	logic             advance, take_in;
	logic [MOD_W-1:0] cur_min, on_min, off_min;
	logic             win_open;
	logic [31:0]      dark_el, bright_el;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_threshold_q <= RST_DARK_THRESHOLD;
			hold_seconds_q   <= RST_HOLD_SECONDS;
			start_hour_q     <= RST_START_HOUR;
			start_minute_q   <= RST_START_MINUTE;
			stop_hour_q      <= RST_STOP_HOUR;
			stop_minute_q    <= RST_STOP_MINUTE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DARK_THRESHOLD: dark_threshold_q <= cfg_wdata;
				REG_HOLD_SECONDS:   hold_seconds_q   <= cfg_wdata;
				REG_START_HOUR:     start_hour_q     <= cfg_wdata[4:0];
				REG_START_MINUTE:   start_minute_q   <= cfg_wdata[5:0];
				REG_STOP_HOUR:      stop_hour_q      <= cfg_wdata[4:0];
				REG_STOP_MINUTE:    stop_minute_q    <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1  <= op_t'(s_axis_tuser);
			smp_s1 <= sample_t'(s_axis_tdata[$bits(sample_t)-1:0]);
		end
	end

	// time-of-day window; a wrapped window is either side of the stop/start gap
	assign cur_min = minute_of_day(smp_s1.day_hour, smp_s1.day_minute);
	assign on_min  = minute_of_day(start_hour_q, start_minute_q);
	assign off_min = minute_of_day(stop_hour_q, stop_minute_q);
	always_comb begin
		if (on_min < off_min)
			win_open = (cur_min > on_min) && (cur_min < off_min);
		else
			win_open = (cur_min > on_min) || (cur_min < off_min);
	end

	assign dark_el   = smp_s1.now_seconds - dark_since_q;
	assign bright_el = smp_s1.now_seconds - bright_since_q;

	always_comb begin
		lamp_n         = lamp_q;
		manual_n       = manual_q;
		preset_n       = preset_q;
		dark_since_n   = dark_since_q;
		bright_since_n = bright_since_q;
		unique case (op_s1)
			OP_CHECK: begin
				if (!manual_q && smp_s1.light_level != 16'd0) begin
					if (smp_s1.clock_known && !win_open) begin
						lamp_n = 1'b0;
					end else if (smp_s1.light_level < dark_threshold_q) begin
						bright_since_n = '0;
						if (preset_q) begin
							lamp_n = 1'b1;
						end else if (dark_since_q != '0) begin
							if (dark_el > 32'(hold_seconds_q))
								lamp_n = 1'b1;
						end else begin
							dark_since_n = smp_s1.now_seconds;
						end
					end else begin
						dark_since_n = '0;
						preset_n     = 1'b0;
						if (bright_since_q != '0) begin
							if (bright_el > 32'(hold_seconds_q))
								lamp_n = 1'b0;
						end else begin
							bright_since_n = smp_s1.now_seconds;
						end
					end
				end
			end
			OP_MANUAL_ON: begin
				lamp_n   = 1'b1;
				manual_n = 1'b1;
			end
			OP_MANUAL_OFF: begin
				lamp_n   = 1'b0;
				manual_n = 1'b1;
			end
			OP_AUTO: begin
				manual_n = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q         <= 1'b0;
			manual_q       <= 1'b0;
			preset_q       <= 1'b1;
			dark_since_q   <= '0;
			bright_since_q <= '0;
		end else if (advance) begin
			lamp_q         <= lamp_n;
			manual_q       <= manual_n;
			preset_q       <= preset_n;
			dark_since_q   <= dark_since_n;
			bright_since_q <= bright_since_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {manual_n, lamp_n};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - 2)'(0), out_data_q};

endmodule

[design/dgls_checker.sv]
// Port-level checks for the daylight gated lamp switch, bound to the top level.
// Depends on dgls_pkg and daylight_gated_lamp_switch_unit_defines.svh.
`include "daylight_gated_lamp_switch_unit_defines.svh"

module dgls_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [dgls_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import dgls_pkg::*;

	// input side only backs off while a result is held up
	`DGLS_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready, "input stalled without a held result")
	// an empty result register always leaves room for a transaction
	`DGLS_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_axis_tvalid,
		s_axis_tready, "input not ready while output empty")
	`DGLS_ASSERT_NEXT(a_valid_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid, "result dropped while stalled")
	`DGLS_ASSERT_NEXT(a_data_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata), "result changed while stalled")

endmodule

bind daylight_gated_lamp_switch_unit dgls_checker u_dgls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
